@@ hdl/smks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smks_pkg
// Shared widths, constants and types for the two-sample Smirnov exact CDF.
// ----------------------------------------------------------------------------
package smks_pkg;

  localparam int MAX_N     = 1024;
  localparam int N_W       = 11;
  localparam int FRAC_BITS = 48;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int WT_W      = FRAC_BITS;
  localparam int D_W       = 20;
  localparam int L_W       = 21;
  localparam int DEN_W     = N_W + 1;
  localparam int RAM_DEPTH = MAX_N + 1;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 56;

  localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic             vld;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [WT_W-1:0]  quo;
  } div_t;

endpackage

@@ hdl/smks_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/smks_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smks_div_cell
// One restoring-division step; hands remainder and quotient to the next cell.
// ----------------------------------------------------------------------------
module smks_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  smks_pkg::div_t      din,
  output smks_pkg::div_t      dout
);
  import smks_pkg::*;

  logic [DEN_W:0] rem2;
  logic           ge;
  logic [DEN_W:0] diff;

  assign rem2 = {din.rem, 1'b0};
  assign ge   = rem2 >= {1'b0, din.den};
  assign diff = rem2 - {1'b0, din.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.den <= din.den;
    dout.rem <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
    dout.quo <= {din.quo[WT_W-2:0], ge};
  end

endmodule

@@ hdl/smks_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smks_mac
// Two-stage Q1.48 multiply: four partial products, then sum and truncate.
// ----------------------------------------------------------------------------
module smks_mac (
  input  logic                      clk,
  input  logic [smks_pkg::WT_W-1:0] weight,
  input  logic [smks_pkg::Q_W-1:0]  value,
  output logic [smks_pkg::Q_W-1:0]  prod
);
  import smks_pkg::*;

  localparam int PW = WT_W + Q_W;

  logic [48:0] p00, p01, p10, p11;
  logic [PW-1:0] sum;

  always_ff @(posedge clk) begin
    p00 <= 49'(weight[23:0])  * 49'(value[24:0]);
    p01 <= 49'(weight[23:0])  * 49'(value[48:25]);
    p10 <= 49'(weight[47:24]) * 49'(value[24:0]);
    p11 <= 49'(weight[47:24]) * 49'(value[48:25]);
  end

  assign sum = PW'(p00) + (PW'(p01) << 25) + (PW'(p10) << 24) + (PW'(p11) << 49);

  always_ff @(posedge clk) begin
    prod <= sum[PW-1:FRAC_BITS];
  end

endmodule

@@ hdl/smirnov_two_sample_exact_cdf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smirnov_two_sample_exact_cdf
// Exact two-sample Smirnov CDF over a lattice row store.
// ----------------------------------------------------------------------------
// One request at a time. With nx <= ny after ordering, a request first seeds
// the row store with ny+1 entries, then per row i runs a weight division
// through the chain of divider cells, ny+1 column updates and a pipeline
// drain. The column loop runs one entry per cycle through the row-store RAM
// port and the two-stage multiplier.
// ----------------------------------------------------------------------------
module smirnov_two_sample_exact_cdf (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [smks_pkg::IN_W-1:0]    s_tdata,  // size_a, size_b, threshold
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [smks_pkg::OUT_W-1:0]   m_tdata   // probability
);
  import smks_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]       state;
  logic [N_W-1:0]   nx, ny, i, j;
  logic [D_W-1:0]   d;
  logic [L_W-1:0]   a_acc, b_acc;
  logic [WT_W-1:0]  weight;
  logic [Q_W-1:0]   prev, res, out_data;
  logic             v_a, v_b, v_c, z_a, z_b, z_c;
  logic [N_W-1:0]   j_a, j_b, j_c;

  logic [N_W-1:0]   sa, sb, ca, cb;
  logic [L_W-1:0]   gap;
  logic             zero_now;
  logic [Q_W-1:0]   rdata, prod, new_val;
  logic [Q_W:0]     sum;
  logic             we;
  logic [N_W-1:0]   waddr;
  logic [Q_W-1:0]   wdata;
  logic             div_go;
  logic [DEN_W-1:0] div_rem, div_den;
  div_t             chain [FRAC_BITS+1];

  function automatic logic [N_W-1:0] clamp(input logic [N_W-1:0] v);
    logic [N_W-1:0] r;
    r = v;
    if (v == '0) r = N_W'(1);
    else if (v > N_W'(MAX_N)) r = N_W'(MAX_N);
    return r;
  endfunction

  assign ca = clamp(s_tdata[10:0]);
  assign cb = clamp(s_tdata[21:11]);
  assign sa = (ca > cb) ? cb : ca;
  assign sb = (ca > cb) ? ca : cb;

  assign gap      = (a_acc > b_acc) ? a_acc - b_acc : b_acc - a_acc;
  assign zero_now = gap > L_W'(d);

  assign s_tready = state == ST_IDLE;
  assign m_tdata  = {{(OUT_W-Q_W){1'b0}}, out_data};

  assign chain[0] = '{vld: div_go, rem: div_rem, den: div_den, quo: '0};
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
    smks_div_cell u_cell (.clk(clk), .rst(rst), .din(chain[k]), .dout(chain[k+1]));
  end

  smks_ram #(.WIDTH(Q_W), .DEPTH(RAM_DEPTH)) u_row (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(j), .rdata(rdata)
  );

  smks_mac u_mac (.clk(clk), .weight(weight), .value(rdata), .prod(prod));

  assign sum     = {1'b0, prod} + {1'b0, prev};
  assign new_val = z_c ? '0 : ((sum > {1'b0, ONE_Q}) ? ONE_Q : sum[Q_W-1:0]);

  always_comb begin
    if (state == ST_INIT) begin
      we    = 1'b1;
      waddr = j;
      wdata = zero_now ? '0 : ONE_Q;
    end else begin
      we    = v_c;
      waddr = j_c;
      wdata = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      div_go   <= 1'b0;
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else begin
      div_go <= (state == ST_INIT && j == ny) ||
                (state == ST_DRAIN && !v_a && !v_b && !v_c && i != nx);
      v_a <= (state == ST_SWEEP);
      v_b <= v_a;
      v_c <= v_b;
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_INIT;
        end
        ST_INIT: begin
          if (j == ny) state <= ST_DIV;
        end
        ST_DIV: begin
          if (chain[FRAC_BITS].vld) state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (j == ny) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!v_a && !v_b && !v_c) begin
            if (i == nx) begin
              state <= ST_DONE;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    j_a <= j;
    z_a <= zero_now;
    j_b <= j_a;
    z_b <= z_a;
    j_c <= j_b;
    z_c <= z_b;
    if (v_c) begin
      prev <= new_val;
      if (j_c == ny) res <= new_val;
    end
    case (state)
      ST_IDLE: begin
        nx    <= sa;
        ny    <= sb;
        d     <= s_tdata[41:22];
        j     <= '0;
        a_acc <= '0;
        b_acc <= '0;
      end
      ST_INIT: begin
        j     <= j + N_W'(1);
        b_acc <= b_acc + L_W'(nx);
        if (j == ny) begin
          i       <= N_W'(1);
          a_acc   <= L_W'(ny);
          div_rem <= DEN_W'(1);
          div_den <= DEN_W'(ny) + DEN_W'(1);
        end
      end
      ST_DIV: begin
        j      <= '0;
        b_acc  <= '0;
        prev   <= '0;
        weight <= chain[FRAC_BITS].quo;
      end
      ST_SWEEP: begin
        j     <= j + N_W'(1);
        b_acc <= b_acc + L_W'(nx);
      end
      ST_DRAIN: begin
        if (!v_a && !v_b && !v_c && i != nx) begin
          i       <= i + N_W'(1);
          a_acc   <= a_acc + L_W'(ny);
          div_rem <= DEN_W'(i) + DEN_W'(1);
          div_den <= DEN_W'(i) + DEN_W'(ny) + DEN_W'(1);
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) out_data <= res;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/smks_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smks_chk
// Port-level checks for the Smirnov exact CDF block.
// ----------------------------------------------------------------------------
module smks_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [smks_pkg::OUT_W-1:0] m_tdata
);
  import smks_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[Q_W-1:0] <= ONE_Q)
    else $error("probability above one");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:Q_W] == '0)
    else $error("nonzero pad bits in result");

endmodule

bind smirnov_two_sample_exact_cdf smks_chk u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-sample Smirnov exact CDF block. Requests
// are driven in random bursts against a randomly stalling result port. Each
// request is predicted by an independent lattice walk in Q1.48. Results are
// compared in order against the predicted probabilities.
// ----------------------------------------------------------------------------
module tb_top;
  import smks_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 8_000_000;

  class cdf_scoreboard;
    longint unsigned prob_q[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     large_seen;

    function automatic longint unsigned mul_q(longint unsigned w, longint unsigned v);
      logic [127:0] p;
      p = 128'(w) * 128'(v);
      return 64'(p >> FRAC_BITS);
    endfunction

    function automatic longint unsigned clamp_n(longint unsigned v);
      if (v == 0) return 1;
      if (v > MAX_N) return MAX_N;
      return v;
    endfunction

    function automatic longint unsigned lattice_prob(longint unsigned a, longint unsigned b,
                                                     longint unsigned d);
      longint unsigned row [0:MAX_N];
      longint unsigned nx, ny, t, w, gap, s, one;
      one = longint'(ONE_Q);
      nx = clamp_n(a);
      ny = clamp_n(b);
      if (nx > ny) begin
        t = nx; nx = ny; ny = t;
      end
      for (longint unsigned j = 0; j <= ny; j++)
        row[j] = (j * nx > d) ? 0 : one;
      for (longint unsigned i = 1; i <= nx; i++) begin
        w = (i << FRAC_BITS) / (i + ny);
        row[0] = (i * ny > d) ? 0 : mul_q(w, row[0]);
        for (longint unsigned j = 1; j <= ny; j++) begin
          gap = (i * ny > j * nx) ? i * ny - j * nx : j * nx - i * ny;
          if (gap > d) row[j] = 0;
          else begin
            s = mul_q(w, row[j]) + row[j-1];
            row[j] = (s > one) ? one : s;
          end
        end
      end
      return row[ny] & ((one << 1) - 1);
    endfunction

    function void note_request(logic [N_W-1:0] a, logic [N_W-1:0] b, logic [D_W-1:0] d);
      if (a >= MAX_N || b >= MAX_N) large_seen++;
      prob_q.push_back(lattice_prob(a, b, d));
    endfunction

    function void check_result(logic [Q_W-1:0] prob);
      longint unsigned exp_p;
      if (prob_q.size() == 0) begin
        $error("probability: unexpected beat, actual %0d", prob);
        errors++;
        return;
      end
      exp_p = prob_q.pop_front();
      checked++;
      if (64'(prob) != exp_p) begin
        $error("probability: expected %0d actual %0d", exp_p, prob);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;  // size_a, size_b, threshold
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;  // probability

  cdf_scoreboard        sb;
  longint unsigned      cycles = 0;
  bit                   hold_out;
  int unsigned          burst_left;
  int unsigned          sent;

  smirnov_two_sample_exact_cdf DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("smirnov_two_sample_exact_cdf regression: fail");
      $finish;
    end
  end

  // result port: own stall pattern, plus one long hold on request
  initial begin
    int unsigned phase;
    bit          held;
    phase = 0;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (12000) @(negedge clk);
      end else begin
        phase++;
        if ((phase / 200) % 3 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[Q_W-1:0]);
  end

  task automatic send_request(logic [N_W-1:0] a, logic [N_W-1:0] b, logic [D_W-1:0] d);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 6);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, d, b, a};
    do @(posedge clk); while (!s_tready);
    sb.note_request(a, b, d);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.prob_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned a, b, nx, ny, d;
    sb = new();
    hold_out = 1'b0;
    burst_left = 0;
    sent = 0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(1, 1, 0);
    send_request(1, 1, 1);
    send_request(0, 0, 0);
    send_request(0, 5, 3);
    send_request(2047, 1, 5);
    send_request(1, 2047, 20'hFFFFF);
    send_request(5, 3, 0);
    send_request(3, 5, 7);
    send_request(7, 7, 0);
    send_request(10, 10, 20'hFFFFF);
    send_request(4, 6, 12);
    send_request(6, 4, 11);
    send_request(1024, 2, 1000);
    send_request(2, 1024, 0);
    send_request(1536, 3, 3000);
    send_request(1024, 1024, 20000);
    send_request(12, 9, 54);
    drain_results();

    for (int k = 0; k < 90; k++) begin
      if (k == 40) hold_out = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(1024, 2047);
        b = $urandom_range(0, 4);
      end else begin
        a = $urandom_range(1, 40);
        b = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 1)) begin
        nx = a; a = b; b = nx;
      end
      nx = (a == 0) ? 1 : (a > MAX_N ? MAX_N : a);
      ny = (b == 0) ? 1 : (b > MAX_N ? MAX_N : b);
      if ($urandom_range(0, 9) < 7) d = $urandom_range(0, nx * ny);
      else d = $urandom_range(0, 20'hFFFFF);
      send_request(a[N_W-1:0], b[N_W-1:0], d[D_W-1:0]);
    end

    drain_results();
    repeat (200) @(negedge clk);
    $display("Covered %0d requests (%0d with a size at or above %0d), %0d results checked.",
             sent, sb.large_seen, MAX_N, sb.checked);
    if (sb.errors == 0 && sb.prob_q.size() == 0)
      $display("smirnov_two_sample_exact_cdf regression: pass");
    else
      $display("smirnov_two_sample_exact_cdf regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/smks_pkg.sv
hdl/smks_ram.sv
hdl/smks_div_cell.sv
hdl/smks_mac.sv
hdl/smirnov_two_sample_exact_cdf.sv
hdl/smks_chk.sv
bench/tb_top.sv
